### sv/record_quicksort_by_key_desc_assert.svh
// assertion macros for the record sort block checker
`ifndef RECORD_QUICKSORT_BY_KEY_DESC_ASSERT_SVH
`define RECORD_QUICKSORT_BY_KEY_DESC_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define RQS_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rqs assertion failed");

// next-cycle implication, disabled while in reset
`define RQS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rqs assertion failed");

`endif

### sv/rqs_pkg.sv
// shared record type and field widths for the record sort block
package rqs_pkg;

    localparam int ID_W    = 16;
    localparam int SCORE_W = 7;
    localparam int REC_W   = ID_W + 3 * SCORE_W;
    localparam int TDATA_W = 40;

    // first member sits in the top bits, so id lands in the low bits
    typedef struct packed {
        logic [SCORE_W-1:0] c;
        logic [SCORE_W-1:0] b;
        logic [SCORE_W-1:0] key;
        logic [ID_W-1:0]    id;
    } rec_t;

endpackage

### sv/rqs_ram.sv
// generic simple dual-port ram with registered read
module rqs_ram #(
    parameter int WIDTH  = 37,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### sv/record_quicksort_by_key_desc.sv
// record collector that sorts by key score, descending, and streams the run out
//
// Records arrive one per input transaction and are written into a record memory
// as they are accepted; tlast marks a set's last record and starts the sort.
// Records past MAX_RECORDS are dropped and every output of that set carries
// tuser = 1. The sort is an in-place quicksort (Lomuto partition, last element
// as pivot) driven from a range stack held in a second memory. Everything goes
// through the single read and single write port of the record memory: each
// partition pops a range and reads its pivot, then compares each record in
// turn, moves a record with a greater key into the next slot, places the pivot
// and pushes the parts left to sort. Output reads each record and loads it into
// the output register once that register is free. Input is not accepted from the
// start of a sort until the last record of the run has been loaded into the output
// register. No clearing pass after reset is needed.
module record_quicksort_by_key_desc #(
    parameter int MAX_RECORDS = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // tag_id [15:0], key_score [22:16], score_b [29:23], score_c [36:30]
    input  logic [rqs_pkg::TDATA_W-1:0] s_tdata,
    input  logic                        s_tlast,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // out_id [15:0], out_key [22:16], out_b [29:23], out_c [36:30]
    output logic [rqs_pkg::TDATA_W-1:0] m_tdata,
    output logic                        m_tlast,
    // overflowed [0]
    output logic                        m_tuser
);

    localparam int IDX_W  = $clog2(MAX_RECORDS);
    localparam int CNT_W  = $clog2(MAX_RECORDS + 1);
    localparam int SPAN_W = 2 * IDX_W;

    typedef enum logic [15:0] {
        S_IDLE    = 16'h0001,
        S_START   = 16'h0002,
        S_POP     = 16'h0004,
        S_LOAD    = 16'h0008,
        S_PIVOT   = 16'h0010,
        S_RD_K    = 16'h0020,
        S_CK_K    = 16'h0040,
        S_SW1     = 16'h0080,
        S_SW2     = 16'h0100,
        S_FIN_RD  = 16'h0200,
        S_FIN_W1  = 16'h0400,
        S_FIN_W2  = 16'h0800,
        S_PUSH1   = 16'h1000,
        S_PUSH2   = 16'h2000,
        S_EMIT_RD = 16'h4000,
        S_EMIT_LD = 16'h8000
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               drop_reg, drop_next;
    logic [CNT_W-1:0]   depth_reg, depth_next;
    logic [CNT_W-1:0]   emit_reg, emit_next;
    logic [IDX_W-1:0]   lo_reg, lo_next;
    logic [IDX_W-1:0]   hi_reg, hi_next;
    logic [IDX_W-1:0]   k_reg, k_next;
    logic [IDX_W-1:0]   slot_reg, slot_next;
    rqs_pkg::rec_t      pivot_reg, pivot_next;
    rqs_pkg::rec_t      tmp_reg, tmp_next;
    rqs_pkg::rec_t      out_rec_reg;
    logic               out_last_reg;
    logic               out_user_reg;
    logic               out_valid_reg, out_valid_next;

    logic               store_we;
    logic [IDX_W-1:0]   store_waddr;
    rqs_pkg::rec_t      store_wdata;
    logic [IDX_W-1:0]   store_raddr;
    rqs_pkg::rec_t      store_rdata;
    logic               stack_we;
    logic [IDX_W-1:0]   stack_waddr;
    logic [SPAN_W-1:0]  stack_wdata;
    logic [IDX_W-1:0]   stack_raddr;
    logic [SPAN_W-1:0]  stack_rdata;

    rqs_pkg::rec_t      in_rec;
    logic [IDX_W-1:0]   k_inc;
    logic [IDX_W-1:0]   slot_inc;
    logic [IDX_W-1:0]   slot_dec;
    logic [CNT_W-1:0]   cnt_dec;
    logic [CNT_W-1:0]   depth_dec;
    logic [CNT_W-1:0]   emit_inc;
    logic               push_right;
    logic               push_left;
    logic               out_free;
    logic               out_load;

    assign in_rec    = rqs_pkg::rec_t'(s_tdata[rqs_pkg::REC_W-1:0]);
    assign k_inc     = k_reg + 1'b1;
    assign slot_inc  = slot_reg + 1'b1;
    assign slot_dec  = slot_reg - 1'b1;
    assign cnt_dec   = count_reg - 1'b1;
    assign depth_dec = depth_reg - 1'b1;
    assign emit_inc  = emit_reg + 1'b1;
    // right part [q+1, hi] and left part [lo, q-1] need sorting only with two or more records
    assign push_right = ({1'b0, slot_reg} + 1'b1) < {1'b0, hi_reg};
    assign push_left  = {1'b0, slot_reg} > ({1'b0, lo_reg} + 1'b1);
    assign out_free   = !out_valid_reg || m_tready;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(rqs_pkg::TDATA_W - rqs_pkg::REC_W){1'b0}}, out_rec_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_user_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        drop_next      = drop_reg;
        depth_next     = depth_reg;
        emit_next      = emit_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        k_next         = k_reg;
        slot_next      = slot_reg;
        pivot_next     = pivot_reg;
        tmp_next       = tmp_reg;
        out_load       = 1'b0;
        store_we       = 1'b0;
        store_waddr    = k_reg;
        store_wdata    = tmp_reg;
        store_raddr    = k_reg;
        stack_we       = 1'b0;
        stack_waddr    = depth_reg[IDX_W-1:0];
        stack_wdata    = {lo_reg, hi_reg};
        stack_raddr    = depth_dec[IDX_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (count_reg < CNT_W'(MAX_RECORDS))
                    begin
                        store_we    = 1'b1;
                        store_waddr = count_reg[IDX_W-1:0];
                        store_wdata = in_rec;
                        count_next  = count_reg + 1'b1;
                    end
                    else
                    begin
                        drop_next = 1'b1;
                    end
                    if (s_tlast)
                    begin
                        state_next = S_START;
                    end
                end
            end
            S_START:
            begin
                emit_next = '0;
                if (count_reg == '0)
                begin
                    drop_next  = 1'b0;
                    state_next = S_IDLE;
                end
                else if (count_reg == CNT_W'(1))
                begin
                    state_next = S_EMIT_RD;
                end
                else
                begin
                    stack_we    = 1'b1;
                    stack_waddr = '0;
                    stack_wdata = {{IDX_W{1'b0}}, cnt_dec[IDX_W-1:0]};
                    depth_next  = CNT_W'(1);
                    state_next  = S_POP;
                end
            end
            S_POP:
            begin
                if (depth_reg == '0)
                begin
                    emit_next  = '0;
                    state_next = S_EMIT_RD;
                end
                else
                begin
                    depth_next = depth_dec;
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                lo_next     = stack_rdata[SPAN_W-1:IDX_W];
                hi_next     = stack_rdata[IDX_W-1:0];
                store_raddr = stack_rdata[IDX_W-1:0];
                state_next  = S_PIVOT;
            end
            S_PIVOT:
            begin
                pivot_next = store_rdata;
                slot_next  = lo_reg;
                k_next     = lo_reg;
                state_next = S_RD_K;
            end
            S_RD_K:
            begin
                store_raddr = k_reg;
                state_next  = S_CK_K;
            end
            S_CK_K:
            begin
                if (store_rdata.key > pivot_reg.key)
                begin
                    tmp_next    = store_rdata;
                    store_raddr = slot_reg;
                    state_next  = S_SW1;
                end
                else if (k_inc == hi_reg)
                begin
                    state_next = S_FIN_RD;
                end
                else
                begin
                    k_next     = k_inc;
                    state_next = S_RD_K;
                end
            end
            S_SW1:
            begin
                // record at slot moves up to k
                store_we    = 1'b1;
                store_waddr = k_reg;
                store_wdata = store_rdata;
                state_next  = S_SW2;
            end
            S_SW2:
            begin
                store_we    = 1'b1;
                store_waddr = slot_reg;
                store_wdata = tmp_reg;
                slot_next   = slot_inc;
                if (k_inc == hi_reg)
                begin
                    state_next = S_FIN_RD;
                end
                else
                begin
                    k_next     = k_inc;
                    state_next = S_RD_K;
                end
            end
            S_FIN_RD:
            begin
                store_raddr = slot_reg;
                state_next  = S_FIN_W1;
            end
            S_FIN_W1:
            begin
                store_we    = 1'b1;
                store_waddr = hi_reg;
                store_wdata = store_rdata;
                state_next  = S_FIN_W2;
            end
            S_FIN_W2:
            begin
                store_we    = 1'b1;
                store_waddr = slot_reg;
                store_wdata = pivot_reg;
                state_next  = S_PUSH1;
            end
            S_PUSH1:
            begin
                if (push_right)
                begin
                    stack_we    = 1'b1;
                    stack_wdata = {slot_inc, hi_reg};
                    depth_next  = depth_reg + 1'b1;
                end
                state_next = S_PUSH2;
            end
            S_PUSH2:
            begin
                // left range pushed last so it is popped first
                if (push_left)
                begin
                    stack_we    = 1'b1;
                    stack_wdata = {lo_reg, slot_dec};
                    depth_next  = depth_reg + 1'b1;
                end
                state_next = S_POP;
            end
            S_EMIT_RD:
            begin
                store_raddr = emit_reg[IDX_W-1:0];
                state_next  = S_EMIT_LD;
            end
            S_EMIT_LD:
            begin
                store_raddr = emit_reg[IDX_W-1:0];
                if (out_free)
                begin
                    out_load  = 1'b1;
                    emit_next = emit_inc;
                    if (emit_inc == count_reg)
                    begin
                        count_next = '0;
                        drop_next  = 1'b0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            drop_reg      <= 1'b0;
            depth_reg     <= '0;
            emit_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            drop_reg      <= drop_next;
            depth_reg     <= depth_next;
            emit_reg      <= emit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        k_reg     <= k_next;
        slot_reg  <= slot_next;
        pivot_reg <= pivot_next;
        tmp_reg   <= tmp_next;
        if (out_load)
        begin
            out_rec_reg  <= store_rdata;
            out_last_reg <= (emit_inc == count_reg);
            out_user_reg <= drop_reg;
        end
    end

    rqs_ram #(
        .WIDTH (rqs_pkg::REC_W),
        .DEPTH (MAX_RECORDS)
    ) u_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (store_waddr),
        .wdata (store_wdata),
        .raddr (store_raddr),
        .rdata (store_rdata)
    );

    rqs_ram #(
        .WIDTH (SPAN_W),
        .DEPTH (MAX_RECORDS)
    ) u_stack (
        .clk   (clk),
        .we    (stack_we),
        .waddr (stack_waddr),
        .wdata (stack_wdata),
        .raddr (stack_raddr),
        .rdata (stack_rdata)
    );

endmodule

### sv/rqs_checker.sv
// port-level checker for the record sort block and its bind
`include "record_quicksort_by_key_desc_assert.svh"

module rqs_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic                        s_tlast,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [rqs_pkg::TDATA_W-1:0] m_tdata,
    input logic                        m_tlast,
    input logic                        m_tuser
);

    logic [rqs_pkg::TDATA_W+1:0]                out_bus;
    logic [rqs_pkg::TDATA_W-rqs_pkg::REC_W-1:0] out_pad;

    assign out_bus = {m_tdata, m_tlast, m_tuser};
    assign out_pad = m_tdata[rqs_pkg::TDATA_W-1:rqs_pkg::REC_W];

    // stalled output holds
    `RQS_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid)
    `RQS_ASSERT_NEXT(a_out_stable, clk, rst_n, m_tvalid && !m_tready, $stable(out_bus))

    // a set's last record starts the sort, so input closes
    `RQS_ASSERT_NEXT(a_sort_blocks_in, clk, rst_n, s_tvalid && s_tready && s_tlast, !s_tready)

    // a record that is not last keeps the block collecting
    `RQS_ASSERT_NEXT(a_collect_open, clk, rst_n, s_tvalid && s_tready && !s_tlast, s_tready)

    // padding above the record stays zero
    `RQS_ASSERT_NOW(a_out_pad, clk, rst_n, m_tvalid, out_pad == '0)

endmodule

bind record_quicksort_by_key_desc rqs_checker u_rqs_checker (.*);
